[hw/rtl/psrd_pkg.sv]
// ----------------------------------------------------------------------------
// psrd_pkg
// Types, codes and helpers shared by the scanline RLE decoder modules.
// ----------------------------------------------------------------------------
package psrd_pkg;

  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned ColW     = 13;
  localparam int unsigned RowW     = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  localparam logic [7:0] PacketSize   = 8'd8;
  localparam logic [7:0] TypeMax      = 8'd2;
  localparam logic [7:0] MixLongCode  = 8'd128;
  localparam logic [7:0] MixRunBias   = 8'd127;

  localparam logic [1:0] TypeRaw = 2'd0;
  localparam logic [1:0] TypeRle = 2'd1;

  localparam logic [2:0] NoChannel = 3'd4;

  typedef enum logic [3:0] {
    PhHeader,
    PhRaw,
    PhRleCount,
    PhRun,
    PhMixCount,
    PhMixHi,
    PhMixLo,
    PhLit,
    PhDone,
    PhSeek,
    PhHalt
  } phase_e;

  typedef enum logic [1:0] {
    StWrite     = 2'd0,
    StBadSize   = 2'd1,
    StBadType   = 2'd2,
    StTruncated = 2'd3
  } status_e;

  typedef enum logic {
    ItemByte,
    ItemEnd
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic [12:0] len;
    logic [1:0]  chan;
    logic [7:0]  value;
    status_e     status;
    logic        done;
  } result_t;

  // first enabled channel at or after 'after'; NoChannel when none
  function automatic logic [2:0] next_channel(input logic [3:0] mask,
                                              input logic [2:0] after);
    logic [2:0] res;
    logic       hit;
    res = NoChannel;
    hit = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (!hit && mask[c] && (3'(c) >= after)) begin
        res = 3'(c);
        hit = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

[hw/rtl/pic_scanline_rle_decoder.sv]
// ----------------------------------------------------------------------------
// pic_scanline_rle_decoder
// Run-length decoder for the body of a PIC image, one byte per request.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per cycle while it is not walking packets
// and the result register is free or being read; bytes pass through a
// two-entry input queue, and each result is held in a result register.
// When a packet ends and the following packets carry no bytes (raw packets
// with no channel enabled, or a zero image width), the decoder walks over
// them in the seek state; it takes no byte meanwhile, the input queue still
// accepts up to two, and a write that ended the packet waits for the walk.
// The packet header phase ends with the same walk over such packets at the
// start of the chain.
// Each result is one channel value over a run of pixels in one row; the
// sink is expected to preload opaque black. After an error result the
// block drains and drops all input until reset. No clearing pass is needed
// after reset.
module pic_scanline_rle_decoder import psrd_pkg::*; #(
  parameter int unsigned PACKET_SLOTS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_value_i,
  input  logic                end_of_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         row_index_o,
  output logic [11:0]         column_start_o,
  output logic [12:0]         run_length_o,
  output logic [1:0]          channel_o,
  output logic [7:0]          pixel_value_o,
  output logic [1:0]          status_o,
  output logic                image_done_o
);

  logic [ColW-1:0] image_width_q, image_width_d;
  logic [RowW-1:0] image_height_q, image_height_d;
  queue_head_t     head;
  logic            pop;
  result_t         res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageWidth:  image_width_d  = cfg_data_i[ColW-1:0];
        CfgImageHeight: image_height_d = cfg_data_i[RowW-1:0];
        default:        image_width_d  = image_width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ColW'(1);
      image_height_q <= RowW'(1);
    end else begin
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
    end
  end

  psrd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_value_i  (byte_value_i),
    .end_of_data_i (end_of_data_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  psrd_back #(
    .PACKET_SLOTS (PACKET_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .head_i         (head),
    .pop_o          (pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .res_o          (res)
  );

  assign row_index_o    = res.row;
  assign column_start_o = res.col;
  assign run_length_o   = res.len;
  assign channel_o      = res.chan;
  assign pixel_value_o  = res.value;
  assign status_o       = res.status;
  assign image_done_o   = res.done;

`ifndef NO_ASSERTIONS
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("decoder popped an empty queue");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head.valid)
    else $error("queue stalls input without a queued item");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StWrite)) |-> (run_length_o <= 13'(MaxWidth)))
    else $error("run longer than the maximum row");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (status_o != StWrite)) |=> !out_valid_o)
    else $error("result after an error");
`endif

endmodule

[hw/rtl/psrd_front.sv]
// ----------------------------------------------------------------------------
// psrd_front
// Accepts body bytes, tags each as data or end of stream, and queues them
// for the decoder in a two-entry queue.
// ----------------------------------------------------------------------------
module psrd_front import psrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_data_i,
  output queue_head_t head_o,
  input  logic        pop_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  item_t            slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  item_t            item_in;
  logic             push;

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    item_in.kind  = end_of_data_i ? ItemEnd : ItemByte;
    item_in.value = end_of_data_i ? 8'h00 : byte_value_i;
  end

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule

[hw/rtl/psrd_back.sv]
// ----------------------------------------------------------------------------
// psrd_back
// Decoder proper: packet header parsing, per-packet scanline decoding and
// the registered result stage.
// ----------------------------------------------------------------------------
module psrd_back import psrd_pkg::*; #(
  parameter int unsigned PACKET_SLOTS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ColW-1:0]   image_width_i,
  input  logic [RowW-1:0]   image_height_i,
  input  queue_head_t       head_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output result_t           res_o
);

  localparam int unsigned CntW = $clog2(PACKET_SLOTS + 1);
  localparam int unsigned PW   = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1;

  logic [5:0]      table_q [PACKET_SLOTS];

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cp_q, cp_d;
  logic [1:0]      hdr_idx_q, hdr_idx_d;
  logic            chained_q, chained_d;
  logic            bad_size_q, bad_size_d;
  logic            bad_type_q, bad_type_d;
  logic [1:0]      hdr_type_q, hdr_type_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] run_q, run_d;
  logic [7:0]      lit_q, lit_d;
  logic [1:0]      chan_q, chan_d;
  logic [7:0]      cnt_hi_q, cnt_hi_d;
  logic [5:0]      cur_entry_q, cur_entry_d;
  logic            out_valid_q, out_valid_d;
  logic            pend_q, pend_d;
  result_t         res_q, res_d;

  logic [7:0]      b;
  logic            step;
  logic [ColW-1:0] w;
  logic [ColW-1:0] rem;
  logic [15:0]     run_n;
  logic [ColW-1:0] clamp;
  logic [ColW-1:0] add_op;
  logic [ColW:0]   col_sum;
  logic            col_end;
  logic [3:0]      mask_cur;
  logic [1:0]      type_cur;
  logic [2:0]      nc0, nc_after;
  logic [7:0]      lit_next;

  logic [CntW-1:0] cp_inc, adv_cp;
  logic            wrap;
  logic [RowW-1:0] adv_row;
  logic            in_seek;
  logic [CntW-1:0] s_cp;
  logic [RowW-1:0] s_row;
  logic [ColW-1:0] s_col;
  logic [5:0]      s_entry;
  logic            seek_done, seek_skip;
  phase_e          seek_phase;
  logic [1:0]      seek_chan;
  logic [2:0]      seek_nc;

  logic            tbl_we;
  logic [5:0]      tbl_entry;
  logic            ep, is_write, err;
  status_e         err_status;

  assign b        = head_i.item.value;
  assign in_seek  = (phase_q == PhSeek);
  assign step     = head_i.valid && !in_seek && (!out_valid_q || out_ready_i);
  assign pop_o    = step;

  assign w        = (image_width_i > ColW'(MaxWidth)) ? ColW'(MaxWidth) : image_width_i;
  assign rem      = (w > col_q) ? w - col_q : '0;
  assign mask_cur = cur_entry_q[3:0];
  assign type_cur = cur_entry_q[5:4];
  assign nc0      = next_channel(mask_cur, 3'd0);
  assign nc_after = next_channel(mask_cur, {1'b0, chan_q} + 3'd1);
  assign lit_next = (lit_q != '0) ? lit_q - 8'd1 : '0;

  // count byte to run length, as the RLE and mixed-packet codes define it
  always_comb begin
    case (phase_q)
      PhMixCount: run_n = (b < MixLongCode) ? 16'(b) + 16'd1 : 16'(b) - 16'(MixRunBias);
      PhMixLo:    run_n = {cnt_hi_q, b};
      default:    run_n = {8'h00, b};
    endcase
  end

  assign clamp = (run_n < {3'b000, rem}) ? run_n[ColW-1:0] : rem;

  always_comb begin
    case (phase_q)
      PhRun:       add_op = run_q;
      PhRaw, PhLit: add_op = ColW'(1);
      default:     add_op = clamp;
    endcase
  end

  assign col_sum = {1'b0, col_q} + {1'b0, add_op};
  assign col_end = (col_sum >= {1'b0, w});

  // packet advance, shared by the seek state and the end of a packet
  assign cp_inc  = cp_q + CntW'(1);
  assign wrap    = (cp_inc >= cnt_q);
  assign adv_cp  = wrap ? '0 : cp_inc;
  assign adv_row = row_q + RowW'(wrap);

  assign s_cp    = in_seek ? cp_q  : adv_cp;
  assign s_row   = in_seek ? row_q : adv_row;
  assign s_col   = in_seek ? col_q : '0;
  assign s_entry = table_q[s_cp[PW-1:0]];

  assign seek_done = (s_row >= image_height_i) || (cnt_q == '0);
  assign seek_skip = (s_col >= w) || ((s_entry[5:4] == TypeRaw) && (s_entry[3:0] == 4'd0));
  assign seek_nc   = next_channel(s_entry[3:0], 3'd0);
  assign seek_chan = seek_nc[1:0];

  always_comb begin
    case (s_entry[5:4])
      TypeRaw: seek_phase = PhRaw;
      TypeRle: seek_phase = PhRleCount;
      default: seek_phase = PhMixCount;
    endcase
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    cp_d        = cp_q;
    hdr_idx_d   = hdr_idx_q;
    chained_d   = chained_q;
    bad_size_d  = bad_size_q;
    bad_type_d  = bad_type_q;
    hdr_type_d  = hdr_type_q;
    row_d       = row_q;
    col_d       = col_q;
    run_d       = run_q;
    lit_d       = lit_q;
    chan_d      = chan_q;
    cnt_hi_d    = cnt_hi_q;
    cur_entry_d = cur_entry_q;
    tbl_we      = 1'b0;
    tbl_entry   = {hdr_type_q, b[4], b[5], b[6], b[7]};
    ep          = 1'b0;
    is_write    = 1'b0;
    err         = 1'b0;
    err_status  = StWrite;

    if (in_seek) begin
      if (seek_done) begin
        phase_d = PhDone;
      end else if (seek_skip) begin
        cp_d  = adv_cp;
        row_d = adv_row;
        col_d = '0;
      end else begin
        phase_d     = seek_phase;
        chan_d      = seek_chan;
        cur_entry_d = s_entry;
      end
    end else if (step && (phase_q != PhDone) && (phase_q != PhHalt)) begin
      if (head_i.item.kind == ItemEnd) begin
        phase_d    = PhHalt;
        err        = 1'b1;
        err_status = StTruncated;
      end else begin
        case (phase_q)
          PhHeader: begin
            case (hdr_idx_q)
              2'd0: begin
                chained_d = (b != 8'h00);
                hdr_idx_d = 2'd1;
              end
              2'd1: begin
                bad_size_d = (b != PacketSize);
                hdr_idx_d  = 2'd2;
              end
              2'd2: begin
                hdr_type_d = b[1:0];
                bad_type_d = (b > TypeMax);
                hdr_idx_d  = 2'd3;
              end
              default: begin
                if (bad_size_q || bad_type_q) begin
                  phase_d    = PhHalt;
                  err        = 1'b1;
                  err_status = bad_size_q ? StBadSize : StBadType;
                end else begin
                  tbl_we    = (cnt_q < CntW'(PACKET_SLOTS));
                  cnt_d     = cnt_q + CntW'(1);
                  hdr_idx_d = 2'd0;
                  if (!chained_q || (cnt_d >= CntW'(PACKET_SLOTS))) begin
                    cp_d    = '0;
                    row_d   = '0;
                    col_d   = '0;
                    phase_d = PhSeek;
                  end
                end
              end
            endcase
          end
          PhMixHi: begin
            cnt_hi_d = b;
            phase_d  = PhMixLo;
          end
          PhMixCount, PhRleCount, PhMixLo: begin
            if ((phase_q == PhMixCount) && (b == MixLongCode)) begin
              phase_d = PhMixHi;
            end else if ((phase_q == PhMixCount) && (b < MixLongCode)) begin
              // literal group
              if (clamp == '0) begin
                ep = 1'b1;
              end else if (mask_cur == 4'd0) begin
                col_d = col_sum[ColW-1:0];
                ep    = col_end;
              end else begin
                lit_d   = clamp[7:0];
                chan_d  = nc0[1:0];
                phase_d = PhLit;
              end
            end else begin
              // repeat run
              if (mask_cur == 4'd0) begin
                col_d = col_sum[ColW-1:0];
                if (col_end) begin
                  ep = 1'b1;
                end else begin
                  phase_d = (phase_q == PhRleCount) ? PhRleCount : PhMixCount;
                end
              end else begin
                run_d   = clamp;
                chan_d  = nc0[1:0];
                phase_d = PhRun;
              end
            end
          end
          PhRaw, PhRun, PhLit: begin
            is_write = 1'b1;
            if (nc_after != NoChannel) begin
              chan_d = nc_after[1:0];
            end else if (phase_q == PhRun) begin
              col_d = col_sum[ColW-1:0];
              if (col_end) begin
                ep = 1'b1;
              end else begin
                phase_d = (type_cur == TypeRle) ? PhRleCount : PhMixCount;
              end
            end else begin
              col_d = col_sum[ColW-1:0];
              if (phase_q == PhLit) begin
                lit_d = lit_next;
              end
              if (col_end) begin
                ep = 1'b1;
              end else if ((phase_q == PhLit) && (lit_next == '0)) begin
                phase_d = PhMixCount;
              end else begin
                chan_d = nc0[1:0];
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    // end of packet: move on and look at the next packet in the same cycle
    if (ep) begin
      cp_d  = adv_cp;
      row_d = adv_row;
      col_d = '0;
      if (seek_done) begin
        phase_d = PhDone;
      end else if (seek_skip) begin
        phase_d = PhSeek;
      end else begin
        phase_d     = seek_phase;
        chan_d      = seek_chan;
        cur_entry_d = s_entry;
      end
    end
  end

  // result stage; a write that ends a packet waits here while empty packets
  // are skipped, so that its done flag is known
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_seek) begin
      if (pend_q && (seek_done || !seek_skip)) begin
        out_valid_d = 1'b1;
        pend_d      = 1'b0;
        res_d.done  = seek_done;
      end
    end else if (err) begin
      res_d.row    = '0;
      res_d.col    = '0;
      res_d.len    = '0;
      res_d.chan   = '0;
      res_d.value  = '0;
      res_d.status = err_status;
      res_d.done   = 1'b0;
      out_valid_d  = 1'b1;
    end else if (is_write) begin
      res_d.row    = row_q;
      res_d.col    = col_q[11:0];
      res_d.len    = (phase_q == PhRun) ? run_q : ColW'(1);
      res_d.chan   = chan_q;
      res_d.value  = b;
      res_d.status = StWrite;
      res_d.done   = ep && seek_done;
      if (ep && !seek_done && seek_skip) begin
        pend_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      cnt_q       <= '0;
      cp_q        <= '0;
      hdr_idx_q   <= '0;
      chained_q   <= 1'b0;
      bad_size_q  <= 1'b0;
      bad_type_q  <= 1'b0;
      hdr_type_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      run_q       <= '0;
      lit_q       <= '0;
      chan_q      <= '0;
      cnt_hi_q    <= '0;
      cur_entry_q <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      cp_q        <= cp_d;
      hdr_idx_q   <= hdr_idx_d;
      chained_q   <= chained_d;
      bad_size_q  <= bad_size_d;
      bad_type_q  <= bad_type_d;
      hdr_type_q  <= hdr_type_d;
      row_q       <= row_d;
      col_q       <= col_d;
      run_q       <= run_d;
      lit_q       <= lit_d;
      chan_q      <= chan_d;
      cnt_hi_q    <= cnt_hi_d;
      cur_entry_q <= cur_entry_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (tbl_we) begin
      table_q[cnt_q[PW-1:0]] <= tbl_entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[sim/tb_pic_scanline_rle_decoder.sv]
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_pic_scanline_rle_decoder
// Self-checking bench for the scanline RLE decoder. Sends one chain of ten
// packet headers, then a directed burst of extreme counts and values, then
// random body bytes shaped by the decode phase, under several image sizes.
// A software decoder predicts every run write; results are checked in order.
// The run ends with either a finished image or a truncated stream.
// ----------------------------------------------------------------------------

import psrd_pkg::*;

class scanline_scoreboard;
  localparam int unsigned Slots = 10;

  int unsigned width_reg;
  int unsigned height_reg;
  phase_e      phase;
  logic [5:0]  slot_table [Slots];
  int unsigned n_packets;
  int unsigned hdr_idx;
  int unsigned hdr_type;
  bit          chained;
  bit          bad_size;
  bit          halted;
  int unsigned pkt;
  int unsigned row;
  int unsigned col;
  int unsigned run_len;
  int unsigned lit_left;
  int unsigned chan;
  int unsigned hi_byte;
  result_t     pending_writes [$];
  int unsigned errors;

  function new();
    width_reg  = 1;
    height_reg = 1;
    phase      = PhHeader;
    foreach (slot_table[i]) slot_table[i] = '0;
    n_packets  = 0;
    hdr_idx    = 0;
    hdr_type   = 0;
    chained    = 1'b0;
    bad_size   = 1'b0;
    halted     = 1'b0;
    pkt        = 0;
    row        = 0;
    col        = 0;
    run_len    = 0;
    lit_left   = 0;
    chan       = 0;
    hi_byte    = 0;
    errors     = 0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == CfgImageWidth) width_reg = data[12:0];
    else height_reg = data;
  endfunction

  function int unsigned pending();
    return pending_writes.size();
  endfunction

  function int unsigned eff_width();
    return (width_reg > MaxWidth) ? MaxWidth : width_reg;
  endfunction

  function logic [5:0] cur_slot();
    return (pkt < Slots) ? slot_table[pkt] : 6'd0;
  endfunction

  function int unsigned first_chan(logic [3:0] m, int unsigned start_ch);
    for (int unsigned c = start_ch; c < 4; c++)
      if (m[c]) return c;
    return 4;
  endfunction

  function int unsigned cols_left();
    return (eff_width() > col) ? eff_width() - col : 0;
  endfunction

  function void next_slot();
    pkt++;
    if (pkt >= n_packets) begin
      pkt = 0;
      row++;
    end
    col = 0;
  endfunction

  // skips packets that carry no bytes; ends the image past the last row
  function void start_packet();
    logic [5:0] e;
    forever begin
      if (row >= height_reg || n_packets == 0) begin
        phase = PhDone;
        return;
      end
      e = cur_slot();
      if (col < eff_width() && !(e[5:4] == TypeRaw && e[3:0] == 4'd0)) begin
        chan = first_chan(e[3:0], 0);
        if (e[5:4] == TypeRaw) phase = PhRaw;
        else if (e[5:4] == TypeRle) phase = PhRleCount;
        else phase = PhMixCount;
        return;
      end
      next_slot();
    end
  endfunction

  function void end_packet();
    next_slot();
    start_packet();
  endfunction

  function void begin_run(int unsigned n, phase_e back);
    logic [5:0]  e;
    int unsigned rc;
    e  = cur_slot();
    rc = (n < cols_left()) ? n : cols_left();
    if (e[3:0] == 4'd0) begin
      col += rc;
      if (col >= eff_width()) end_packet();
      else phase = back;
      return;
    end
    run_len = rc;
    chan    = first_chan(e[3:0], 0);
    phase   = PhRun;
  endfunction

  function void begin_literal(int unsigned n);
    logic [5:0]  e;
    int unsigned k;
    e = cur_slot();
    k = (n < cols_left()) ? n : cols_left();
    if (k == 0) begin
      end_packet();
      return;
    end
    if (e[3:0] == 4'd0) begin
      col += k;
      if (col >= eff_width()) end_packet();
      return;
    end
    lit_left = k;
    chan     = first_chan(e[3:0], 0);
    phase    = PhLit;
  endfunction

  function void add_write(input int unsigned r, c, len, ch, input logic [7:0] v,
                          input status_e st, input bit done);
    result_t res;
    res.row    = r[15:0];
    res.col    = c[11:0];
    res.len    = len[12:0];
    res.chan   = ch[1:0];
    res.value  = v;
    res.status = st;
    res.done   = done;
    pending_writes = {pending_writes, res};
  endfunction

  // advance the decoder by one accepted request
  function void decode_byte(logic [7:0] b, logic eod);
    int unsigned v;
    int unsigned r;
    int unsigned c;
    int unsigned len;
    int unsigned ch;
    int unsigned nc;
    logic [3:0]  m;
    logic [5:0]  e;
    v = b;
    if (halted || phase == PhDone) return;
    if (eod) begin
      halted = 1'b1;
      add_write(0, 0, 0, 0, 8'd0, StTruncated, 1'b0);
      return;
    end
    if (phase == PhHeader) begin
      case (hdr_idx)
        0: chained = (b != 8'd0);
        1: bad_size = (b != PacketSize);
        2: hdr_type = v;
        default: begin
          if (bad_size || hdr_type > TypeMax) begin
            halted = 1'b1;
            add_write(0, 0, 0, 0, 8'd0, bad_size ? StBadSize : StBadType, 1'b0);
            return;
          end
          // mask byte is bit-reversed: bit 7 enables red
          m = {b[4], b[5], b[6], b[7]};
          if (n_packets < Slots) slot_table[n_packets] = {hdr_type[1:0], m};
          n_packets++;
          hdr_idx = 0;
          if (!chained || n_packets >= Slots) begin
            pkt = 0;
            row = 0;
            col = 0;
            start_packet();
          end
          return;
        end
      endcase
      hdr_idx = (hdr_idx + 1) % 4;
      return;
    end

    case (phase)
      PhRleCount: begin
        begin_run(v, PhRleCount);
        return;
      end
      PhMixCount: begin
        if (v < MixLongCode) begin_literal(v + 1);
        else if (v == MixLongCode) phase = PhMixHi;
        else begin_run(v - MixRunBias, PhMixCount);
        return;
      end
      PhMixHi: begin
        hi_byte = v;
        phase = PhMixLo;
        return;
      end
      PhMixLo: begin
        begin_run((hi_byte << 8) | v, PhMixCount);
        return;
      end
      default: ;
    endcase

    // value byte of a raw pixel, a run or a literal pixel
    e   = cur_slot();
    m   = e[3:0];
    r   = row;
    c   = col;
    ch  = chan;
    len = (phase == PhRun) ? run_len : 1;
    nc  = first_chan(m, ch + 1);
    if (nc < 4) begin
      chan = nc;
    end else if (phase == PhRun) begin
      col += run_len;
      if (col >= eff_width()) end_packet();
      else phase = (e[5:4] == TypeRle) ? PhRleCount : PhMixCount;
    end else begin
      col++;
      if (phase == PhLit && lit_left > 0) lit_left--;
      if (col >= eff_width()) end_packet();
      else if (phase == PhLit && lit_left == 0) phase = PhMixCount;
      else chan = first_chan(m, 0);
    end
    add_write(r, c, len, ch, b, StWrite, phase == PhDone);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_write(result_t got);
    result_t exp_r;
    if (pending_writes.size() == 0) begin
      report($sformatf("unexpected write row %0d col %0d status %0d",
                       got.row, got.col, got.status));
      return;
    end
    exp_r = pending_writes.pop_front();
    if (got.row !== exp_r.row)
      report($sformatf("row_index got %0d want %0d", got.row, exp_r.row));
    if (got.col !== exp_r.col)
      report($sformatf("column_start got %0d want %0d", got.col, exp_r.col));
    if (got.len !== exp_r.len)
      report($sformatf("run_length got %0d want %0d", got.len, exp_r.len));
    if (got.chan !== exp_r.chan)
      report($sformatf("channel got %0d want %0d", got.chan, exp_r.chan));
    if (got.value !== exp_r.value)
      report($sformatf("pixel_value got %0h want %0h", got.value, exp_r.value));
    if (got.status !== exp_r.status)
      report($sformatf("status got %0d want %0d", got.status, exp_r.status));
    if (got.done !== exp_r.done)
      report($sformatf("image_done got %0d want %0d", got.done, exp_r.done));
  endtask

  task final_check();
    if (pending_writes.size() != 0)
      report($sformatf("%0d writes never arrived", pending_writes.size()));
  endtask
endclass

module tb_pic_scanline_rle_decoder;
  localparam int unsigned CycleLimit = 600000;
  localparam logic [1:0]  TypeMix    = 2'd2;

  bit                  clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          byte_value_i;
  logic                end_of_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [15:0]         row_index_o;
  logic [11:0]         column_start_o;
  logic [12:0]         run_length_o;
  logic [1:0]          channel_o;
  logic [7:0]          pixel_value_o;
  logic [1:0]          status_o;
  logic                image_done_o;

  scanline_scoreboard sb = new();
  bit                 in_burst;
  bit                 out_burst;
  int unsigned        cycles;
  int unsigned        ready_hold;

  pic_scanline_rle_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .end_of_data_i  (end_of_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_index_o    (row_index_o),
    .column_start_o (column_start_o),
    .run_length_o   (run_length_o),
    .channel_o      (channel_o),
    .pixel_value_o  (pixel_value_o),
    .status_o       (status_o),
    .image_done_o   (image_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.row    = row_index_o;
      got.col    = column_start_o;
      got.len    = run_length_o;
      got.chan   = channel_o;
      got.value  = pixel_value_o;
      got.status = status_e'(status_o);
      got.done   = image_done_o;
      sb.check_write(got);
    end
  end

  // sink back-pressure: short stalls mostly, a long one now and then
  initial begin
    out_ready_i = 1'b0;
    ready_hold  = 0;
    forever begin
      @(negedge clk_i);
      if (out_burst) begin
        out_ready_i = 1'b1;
      end else if (ready_hold > 0) begin
        ready_hold--;
      end else if (!out_ready_i) begin
        out_ready_i = 1'b1;
        ready_hold  = $urandom_range(0, 8);
      end else begin
        out_ready_i = 1'b0;
        ready_hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 2);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_burst || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] mask_byte(logic [3:0] m);
    return {m[0], m[1], m[2], m[3], 4'($urandom_range(0, 15))};
  endfunction

  // next body byte, chosen from what the decoder expects to see next
  function automatic logic [7:0] pick_byte(bit directed, int k);
    int r;
    r = $urandom_range(0, 99);
    case (sb.phase)
      PhRleCount, PhMixCount: begin
        if (directed) begin
          case (k % 6)
            0: return 8'd0;
            1: return 8'd127;
            2: return MixLongCode;
            3: return 8'd129;
            4: return 8'd255;
            default: return 8'd1;
          endcase
        end
        if (sb.phase == PhRleCount)
          return (r < 40) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(0, 255));
        if (r < 45) return 8'($urandom_range(0, 7));
        if (r < 55) return 8'($urandom_range(0, 127));
        if (r < 85) return 8'($urandom_range(129, 255));
        return MixLongCode;
      end
      PhMixHi: begin
        if (directed) return (k % 2) ? 8'hFF : 8'h00;
        if (r < 70) return 8'd0;
        if (r < 90) return 8'($urandom_range(1, 15));
        return 8'($urandom_range(0, 255));
      end
      default: begin
        if (directed) return (k % 2) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_byte(logic [7:0] b, logic eod);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    byte_value_i  = b;
    end_of_data_i = eod;
    do @(posedge clk_i); while (!in_ready_o);
    sb.decode_byte(b, eod);
  endtask

  // all writes in, then room for a trailing packet walk
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0]  plan_type [10];
    logic [3:0]  plan_mask [10];
    int unsigned w;
    int          r;
    int          n;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgImageWidth;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    byte_value_i  = '0;
    end_of_data_i = 1'b0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    cycles        = 0;
    // every packet kind, empty masks included; slot 0 always carries bytes
    plan_type = '{TypeRaw, TypeRaw, TypeRle, TypeMix, TypeMix,
                  TypeRle, TypeRaw, TypeMix, TypeRle, TypeRaw};
    plan_mask = '{4'hF, 4'h0, 4'($urandom_range(1, 15)), 4'hF, 4'h0,
                  4'h0, 4'h8, 4'($urandom_range(0, 15)), 4'hF,
                  4'($urandom_range(1, 15))};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(CfgImageWidth, 16'(MaxWidth));
    cfg_write(CfgImageHeight, 16'd1);
    // ten headers, the last one still chained: slot limit stops parsing
    for (int i = 0; i < 10; i++) begin
      push_byte(8'($urandom_range(1, 255)), 1'b0);
      push_byte(PacketSize, 1'b0);
      push_byte({6'd0, plan_type[i]}, 1'b0);
      push_byte(mask_byte(plan_mask[i]), 1'b0);
    end
    for (int k = 0; k < 8; k++) push_byte((k % 2) ? 8'hFF : 8'h00, 1'b0);

    // shrink the row under the open packet, then extreme counts
    wait_idle();
    cfg_write(CfgImageWidth, 16'd1);
    cfg_write(CfgImageHeight, 16'hFFFF);
    for (int k = 0; k < 18; k++) push_byte(pick_byte(1'b1, k), 1'b0);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (p == 1) w = MaxWidth;
      else if (p == 3) w = 1;
      else if (r < 60) w = $urandom_range(1, 12);
      else if (r < 90) w = $urandom_range(13, 300);
      else w = $urandom_range(301, MaxWidth);
      cfg_write(CfgImageWidth, 16'(w));
      in_burst  = (p == 2);
      out_burst = (p == 4);
      for (int k = 0; k < 140; k++) push_byte(pick_byte(1'b0, 0), 1'b0);
    end

    wait_idle();
    in_burst  = 1'b0;
    out_burst = 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      // make the current row the last one and run to completion
      cfg_write(CfgImageWidth, 16'($urandom_range(1, 8)));
      cfg_write(CfgImageHeight, 16'(sb.row + 1));
      n = 0;
      while (sb.phase != PhDone && n < 4000) begin
        push_byte(pick_byte(1'b0, 0), 1'b0);
        n++;
      end
      // a finished image ignores end of stream as well
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    repeat (3) push_byte(8'($urandom_range(0, 255)), 1'b0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    sb.final_check();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
